// ===== src/assert_macros.svh =====
// assertion macros for the hex parser modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define IHEX_ASSERT_HOLDS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IHEX_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ihex_pkg.sv =====
// shared types, codes and constants for the intel hex record parser
// no dependencies; used by every module of the parser
package ihex_pkg;

   // character and digit constants
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] HEX_A_OFFSET = 8'd55;
   localparam logic [7:0] DIGIT_OFFSET = 8'd48;
   localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

   // record types
   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_END  = 8'h01;

   // write limit register
   localparam int unsigned LIMIT_W = 17;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd32768;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 17'd65536;

   // result kinds
   typedef enum logic [2:0] {
      KIND_WRITE    = 3'd0,
      KIND_END_OK   = 3'd1,
      KIND_END_WARN = 3'd2,
      KIND_BAD_TYPE = 3'd3,
      KIND_NO_COLON = 3'd4
   } kind_type;

   // one input character
   typedef struct packed {
      logic [7:0] char_code;
      logic       file_start;
   } item_type;

   // one result
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [7:0]  data;
   } result_type;

   // digit decode: A-F and 0-9 map to values, anything else keeps its code
   function automatic logic [7:0] decode_digit(input logic [7:0] c);
      logic [7:0] d;
      d = c;
      if (c inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         d = c - HEX_A_OFFSET;
      end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         d = c - DIGIT_OFFSET;
      end
      return d;
   endfunction

endpackage

// ===== src/ihex_in_reg.sv =====
// input register stage of the hex parser
// depends on ihex_pkg for the item type
module ihex_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ihex_pkg::item_type req_item,
   input  logic              advance,
   output logic              item_valid,
   output ihex_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   ihex_pkg::item_type item_ff;

   // room when empty or when the held item moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload captured on each input transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/ihex_parser.sv =====
// record parse state and result logic of the hex parser
// depends on ihex_pkg and assert_macros.svh
`include "assert_macros.svh"

module ihex_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  ihex_pkg::item_type                 item,
   input  logic [ihex_pkg::LIMIT_W-1:0]       write_limit,
   output logic                               emit,
   output ihex_pkg::result_type               result
);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_LEN     = 3'd1,
      PH_ADDR_HI = 3'd2,
      PH_ADDR_LO = 3'd3,
      PH_TYPE    = 3'd4,
      PH_DATA    = 3'd5,
      PH_CSUM    = 3'd6,
      PH_ENDB    = 3'd7
   } phase_type;

   phase_type                     phase_ff, phase_in;
   logic                          nibble_ff, nibble_in;
   logic [7:0]                    high_ff, high_in;
   logic [7:0]                    bytes_ff, bytes_in;
   logic [7:0]                    addr_high_ff, addr_high_in;
   logic [ihex_pkg::LIMIT_W-1:0]  cur_addr_ff, cur_addr_in;
   logic                          done_ff, done_in;

   logic [7:0]                    digit;
   logic [7:0]                    byte_val;
   logic [ihex_pkg::LIMIT_W-1:0]  limit_eff;

   // decoded digit and assembled byte
   assign digit     = ihex_pkg::decode_digit(item.char_code);
   assign byte_val  = {high_ff[3:0], 4'b0000} + digit;
   assign limit_eff = (write_limit > ihex_pkg::LIMIT_MAX) ? ihex_pkg::LIMIT_MAX : write_limit;

   // next state and result
   always_comb begin
      phase_in     = phase_ff;
      nibble_in    = nibble_ff;
      high_in      = high_ff;
      bytes_in     = bytes_ff;
      addr_high_in = addr_high_ff;
      cur_addr_in  = cur_addr_ff;
      done_in      = done_ff;
      emit         = 1'b0;
      result       = '0;
      if (advance) begin
         if (item.file_start) begin
            // new file clears everything
            phase_in     = PH_IDLE;
            nibble_in    = 1'b0;
            high_in      = '0;
            bytes_in     = '0;
            addr_high_in = '0;
            cur_addr_in  = '0;
            done_in      = 1'b0;
            if (item.char_code != ihex_pkg::CHAR_COLON) begin
               done_in     = 1'b1;
               emit        = 1'b1;
               result.kind = ihex_pkg::KIND_NO_COLON;
            end else begin
               phase_in = PH_LEN;
            end
         end else if (done_ff) begin
            // stopped until the next file start
         end else if (item.char_code == ihex_pkg::CHAR_COLON) begin
            phase_in  = PH_LEN;
            nibble_in = 1'b0;
         end else if (phase_ff == PH_IDLE) begin
            // characters between records are dropped
         end else if (!nibble_ff) begin
            high_in   = digit;
            nibble_in = 1'b1;
         end else begin
            nibble_in = 1'b0;
            case (phase_ff)
               PH_LEN: begin
                  bytes_in = byte_val;
                  phase_in = PH_ADDR_HI;
               end
               PH_ADDR_HI: begin
                  addr_high_in = byte_val;
                  phase_in     = PH_ADDR_LO;
               end
               PH_ADDR_LO: begin
                  cur_addr_in = {1'b0, addr_high_ff, byte_val};
                  phase_in    = PH_TYPE;
               end
               PH_TYPE: begin
                  if (byte_val == ihex_pkg::REC_DATA) begin
                     phase_in = (bytes_ff == 8'd0) ? PH_CSUM : PH_DATA;
                  end else if (byte_val == ihex_pkg::REC_END) begin
                     phase_in = PH_ENDB;
                  end else begin
                     done_in     = 1'b1;
                     phase_in    = PH_IDLE;
                     emit        = 1'b1;
                     result.kind = ihex_pkg::KIND_BAD_TYPE;
                  end
               end
               PH_DATA: begin
                  // memory write only below the limit
                  if (cur_addr_ff < limit_eff) begin
                     emit           = 1'b1;
                     result.kind    = ihex_pkg::KIND_WRITE;
                     result.address = cur_addr_ff[15:0];
                     result.data    = byte_val;
                  end
                  cur_addr_in = cur_addr_ff + 1'b1;
                  bytes_in    = bytes_ff - 8'd1;
                  if (bytes_in == 8'd0) begin
                     phase_in = PH_CSUM;
                  end
               end
               PH_CSUM: begin
                  phase_in = PH_IDLE;
               end
               PH_ENDB: begin
                  done_in     = 1'b1;
                  phase_in    = PH_IDLE;
                  emit        = 1'b1;
                  result.kind = (byte_val == ihex_pkg::BYTE_ALL_ONES) ?
                                ihex_pkg::KIND_END_OK : ihex_pkg::KIND_END_WARN;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         nibble_ff    <= 1'b0;
         high_ff      <= '0;
         bytes_ff     <= '0;
         addr_high_ff <= '0;
         cur_addr_ff  <= '0;
         done_ff      <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         nibble_ff    <= nibble_in;
         high_ff      <= high_in;
         bytes_ff     <= bytes_in;
         addr_high_ff <= addr_high_in;
         cur_addr_ff  <= cur_addr_in;
         done_ff      <= done_in;
      end
   end

   // checks
   `IHEX_ASSERT_HOLDS(a_quiet_when_done, clock, reset, !(done_ff && !item.file_start && emit), "result while parser stopped")
   `IHEX_ASSERT_HOLDS(a_write_in_data, clock, reset, !(emit && result.kind == ihex_pkg::KIND_WRITE) || phase_ff == PH_DATA, "data write outside data phase")
   `IHEX_ASSERT_NEXT(a_stop_after_status, clock, reset, emit && result.kind != ihex_pkg::KIND_WRITE, done_ff && phase_ff == PH_IDLE, "parser did not stop after status")

endmodule

// ===== src/ihex_rsp_reg.sv =====
// result register of the hex parser
// depends on ihex_pkg for the result type
module ihex_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ihex_pkg::result_type load_result,
   output logic                 can_take,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ihex_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   ihex_pkg::result_type result_ff;

   // slot is free when empty or draining this cycle
   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== src/intel_hex_record_parser_core.sv =====
// a character is parsed out of the input register; its result, if any, is registered onto rsp_*
// throughput: one character per cycle; only a held result with rsp_ready low stalls input
// the single parse stage between input and result registers sets the rate
// reset (synchronous, active high): parser waits for a colon, write limit returns to 32768
// top level of the intel hex record parser; depends on ihex_pkg, ihex_in_reg,
// ihex_parser and ihex_rsp_reg
module intel_hex_record_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_code,
   input  logic                          req_file_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_kind,
   output logic [15:0]                   rsp_address,
   output logic [7:0]                    rsp_data,
   input  logic                          csr_wr_en,
   input  logic [ihex_pkg::LIMIT_W-1:0]  csr_wr_data
);

   logic [ihex_pkg::LIMIT_W-1:0] write_limit_ff;
   ihex_pkg::item_type           req_item;
   ihex_pkg::item_type           stage_item;
   logic                         stage_valid;
   logic                         can_take;
   logic                         advance;
   logic                         emit;
   ihex_pkg::result_type         parse_result;
   ihex_pkg::result_type         rsp_result;

   // write limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         write_limit_ff <= ihex_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         write_limit_ff <= csr_wr_data;
      end
   end

   assign req_item.char_code  = req_char_code;
   assign req_item.file_start = req_file_start;

   // held character moves through the parser when the result slot is free
   assign advance = stage_valid && can_take;

   ihex_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (stage_valid),
      .item       (stage_item)
   );

   ihex_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (stage_item),
      .write_limit (write_limit_ff),
      .emit        (emit),
      .result      (parse_result)
   );

   ihex_rsp_reg u_rsp_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (emit),
      .load_result (parse_result),
      .can_take    (can_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_result  (rsp_result)
   );

   assign rsp_kind    = rsp_result.kind;
   assign rsp_address = rsp_result.address;
   assign rsp_data    = rsp_result.data;

endmodule

// ===== dv/tb_intel_hex_record_parser_core.sv =====
// self-checking testbench for the intel hex record parser core: feeds hex files one
// character per transfer, predicts writes and end/error reports, and checks each result
// depends on ihex_pkg and intel_hex_record_parser_core
module tb_intel_hex_record_parser_core;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_Q  = 8'h51;

   typedef enum logic [2:0] {
      AWAIT_COLON,
      GET_LENGTH,
      GET_ADDR_HI,
      GET_ADDR_LO,
      GET_TYPE,
      GET_DATA,
      GET_CHECKSUM,
      GET_END_BYTE
   } field_phase_type;

   typedef struct {
      ihex_pkg::kind_type kind;
      logic [15:0]        address;
      logic [7:0]         data;
   } parse_event_type;

   // dut ports
   logic                         clock          = 1'b0;
   logic                         reset          = 1'b1;
   logic                         req_valid      = 1'b0;
   logic [7:0]                   req_char_code  = 8'h00;
   logic                         req_file_start = 1'b0;
   logic                         rsp_ready      = 1'b0;
   logic                         csr_wr_en      = 1'b0;
   logic [ihex_pkg::LIMIT_W-1:0] csr_wr_data    = '0;
   logic                         req_ready;
   logic                         rsp_valid;
   logic [2:0]                   rsp_kind;
   logic [15:0]                  rsp_address;
   logic [7:0]                   rsp_data;

   // parser state as predicted
   logic [ihex_pkg::LIMIT_W-1:0] model_limit = ihex_pkg::LIMIT_RESET;
   field_phase_type              phase       = AWAIT_COLON;
   logic                         digit_held  = 1'b0;
   logic [7:0]                   first_digit = 8'h00;
   logic [7:0]                   bytes_left  = 8'h00;
   logic [7:0]                   addr_high   = 8'h00;
   logic [16:0]                  write_addr  = 17'h0;
   logic                         stopped     = 1'b0;
   parse_event_type              pending_events[$];

   // bookkeeping and traffic shaping
   int error_count     = 0;
   int chars_sent      = 0;
   int results_checked = 0;
   int writes_checked  = 0;
   int idle_pct        = 0;
   int stall_pct       = 0;
   int noise_pct       = 0;
   int hold_request    = 0;
   int hold_left       = 0;
   int quiet_cycles    = 0;

   intel_hex_record_parser_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .req_file_start (req_file_start),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_address    (rsp_address),
      .rsp_data       (rsp_data),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #1 clock = ~clock;

   // hex digit value; anything outside 0-9 and A-F passes through unchanged
   function automatic logic [7:0] char_value(input logic [7:0] c);
      if (c inside {[ihex_pkg::CHAR_ZERO:ihex_pkg::CHAR_NINE]})
         return c - ihex_pkg::DIGIT_OFFSET;
      if (c inside {[ihex_pkg::CHAR_UPPER_A:ihex_pkg::CHAR_UPPER_F]})
         return c - ihex_pkg::HEX_A_OFFSET;
      return c;
   endfunction

   function automatic logic [7:0] digit_char(input logic [3:0] n);
      if (n < 4'd10) return ihex_pkg::CHAR_ZERO + n;
      return ihex_pkg::CHAR_UPPER_A + (n - 4'd10);
   endfunction

   function automatic void note_result(input ihex_pkg::kind_type k, input logic [15:0] a,
                                       input logic [7:0] d);
      parse_event_type ev;
      ev.kind    = k;
      ev.address = a;
      ev.data    = d;
      pending_events.push_back(ev);
   endfunction

   // advance the predicted parser by one character
   function automatic void parse_char(input logic [7:0] c, input logic fs);
      logic [7:0]                   b;
      logic [ihex_pkg::LIMIT_W-1:0] cap;
      if (fs) begin
         phase       = AWAIT_COLON;
         digit_held  = 1'b0;
         first_digit = 8'h00;
         bytes_left  = 8'h00;
         addr_high   = 8'h00;
         write_addr  = 17'h0;
         stopped     = 1'b0;
         if (c != ihex_pkg::CHAR_COLON) begin
            stopped = 1'b1;
            note_result(ihex_pkg::KIND_NO_COLON, 16'h0, 8'h0);
         end else begin
            phase = GET_LENGTH;
         end
         return;
      end
      if (stopped) return;
      if (c == ihex_pkg::CHAR_COLON) begin
         phase      = GET_LENGTH;
         digit_held = 1'b0;
         return;
      end
      if (phase == AWAIT_COLON) return;
      if (!digit_held) begin
         first_digit = char_value(c);
         digit_held  = 1'b1;
         return;
      end
      digit_held = 1'b0;
      b = {first_digit[3:0], 4'h0} + char_value(c);
      case (phase)
         GET_LENGTH: begin
            bytes_left = b;
            phase = GET_ADDR_HI;
         end
         GET_ADDR_HI: begin
            addr_high = b;
            phase = GET_ADDR_LO;
         end
         GET_ADDR_LO: begin
            write_addr = {1'b0, addr_high, b};
            phase = GET_TYPE;
         end
         GET_TYPE: begin
            if (b == ihex_pkg::REC_DATA) begin
               if (bytes_left == 8'h00) phase = GET_CHECKSUM;
               else phase = GET_DATA;
            end else if (b == ihex_pkg::REC_END) begin
               phase = GET_END_BYTE;
            end else begin
               stopped = 1'b1;
               phase = AWAIT_COLON;
               note_result(ihex_pkg::KIND_BAD_TYPE, 16'h0, 8'h0);
            end
         end
         GET_DATA: begin
            cap = (model_limit > ihex_pkg::LIMIT_MAX) ? ihex_pkg::LIMIT_MAX : model_limit;
            if (write_addr < cap) note_result(ihex_pkg::KIND_WRITE, write_addr[15:0], b);
            write_addr = write_addr + 17'd1;
            bytes_left = bytes_left - 8'd1;
            if (bytes_left == 8'h00) phase = GET_CHECKSUM;
         end
         GET_END_BYTE: begin
            stopped = 1'b1;
            phase = AWAIT_COLON;
            if (b == ihex_pkg::BYTE_ALL_ONES) note_result(ihex_pkg::KIND_END_OK, 16'h0, 8'h0);
            else note_result(ihex_pkg::KIND_END_WARN, 16'h0, 8'h0);
         end
         default: begin
            phase = AWAIT_COLON;
         end
      endcase
   endfunction

   // one character transfer, with random sender gaps ahead of it
   task automatic send_char(input logic [7:0] c, input logic fs);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_char_code  <= c;
      req_file_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_char(c, fs);
      chars_sent++;
   endtask

   // two digits, each occasionally replaced by a random character
   task automatic send_hex_byte(input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = digit_char(b[7:4]);
      lo = digit_char(b[3:0]);
      if ($urandom_range(99) < noise_pct) hi = 8'($urandom_range(255));
      if ($urandom_range(99) < noise_pct) lo = 8'($urandom_range(255));
      send_char(hi, 1'b0);
      send_char(lo, 1'b0);
   endtask

   // end_byte is only sent for end records; data records get a real checksum
   task automatic send_record(input logic new_file, input int len, input logic [15:0] addr,
                              input logic [7:0] rtype, input logic [7:0] end_byte);
      logic [7:0] sum;
      logic [7:0] payload;
      int         i;
      send_char(ihex_pkg::CHAR_COLON, new_file);
      sum = len[7:0] + addr[15:8] + addr[7:0] + rtype;
      send_hex_byte(len[7:0]);
      send_hex_byte(addr[15:8]);
      send_hex_byte(addr[7:0]);
      send_hex_byte(rtype);
      if (rtype == ihex_pkg::REC_DATA) begin
         for (i = 0; i < len; i++) begin
            payload = 8'($urandom_range(255));
            sum += payload;
            send_hex_byte(payload);
         end
         send_hex_byte(8'h00 - sum);
      end else if (rtype == ihex_pkg::REC_END) begin
         send_hex_byte(end_byte);
      end
   endtask

   // sender pause until every predicted result has come back
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_write_limit(input logic [ihex_pkg::LIMIT_W-1:0] value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_limit = value;
   endtask

   // a file of mostly well-formed records, with some noise and broken ones
   task automatic send_random_file();
      int                           n_records;
      int                           r;
      int                           pick;
      int                           len;
      int                           base;
      logic                         first;
      logic [15:0]                  addr;
      logic [7:0]                   c;
      logic [ihex_pkg::LIMIT_W-1:0] cap;
      pick = $urandom_range(99);
      if (pick < 4) begin
         c = 8'($urandom_range(255));
         if (c == ihex_pkg::CHAR_COLON) c = CHAR_LF;
         send_char(c, 1'b1);
         send_char(ihex_pkg::CHAR_COLON, 1'b0);
         return;
      end
      cap = (model_limit > ihex_pkg::LIMIT_MAX) ? ihex_pkg::LIMIT_MAX : model_limit;
      n_records = $urandom_range(5, 1);
      for (r = 0; r < n_records; r++) begin
         first = (r == 0) && ($urandom_range(99) >= 3);
         pick = $urandom_range(99);
         len = (pick < 80) ? $urandom_range(16, 0) :
               (pick < 97) ? $urandom_range(48, 17) : $urandom_range(255, 200);
         pick = $urandom_range(99);
         if (pick < 40) begin
            base = int'(cap) - int'($urandom_range(len + 2, 1));
            addr = (base < 0) ? 16'h0000 : base[15:0];
         end else if (pick < 60) begin
            addr = 16'(16'hFFFF - $urandom_range(8, 0));
         end else begin
            addr = 16'($urandom_range(16'hFFFF, 0));
         end
         pick = $urandom_range(99);
         if (pick < 5) begin
            // record cut short by the next colon
            send_char(ihex_pkg::CHAR_COLON, first);
            repeat ($urandom_range(6, 1))
               send_char(digit_char(4'($urandom_range(15))), 1'b0);
         end else if (pick < 9) begin
            send_record(first, len, addr, 8'($urandom_range(255, 2)), 8'h00);
            return;
         end else begin
            send_record(first, len, addr, ihex_pkg::REC_DATA, 8'h00);
         end
         if ($urandom_range(99) < 30) begin
            send_char(CHAR_CR, 1'b0);
            send_char(CHAR_LF, 1'b0);
         end
      end
      send_record(1'b0, 0, 16'h0000, ihex_pkg::REC_END,
                  ($urandom_range(99) < 75) ? ihex_pkg::BYTE_ALL_ONES :
                                              8'($urandom_range(255)));
   endtask

   task automatic test_ignored_before_file_start();
      // stray characters after reset are dropped until a colon arrives
      send_char(digit_char(4'h5), 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
   endtask

   task automatic test_data_records();
      // at the reset limit the byte at 7FFF writes and the one at 8000 does not
      send_record(1'b1, 2, 16'h7FFF, ihex_pkg::REC_DATA, 8'h00);
      // empty record goes straight to its checksum
      send_record(1'b0, 0, 16'h0000, ihex_pkg::REC_DATA, 8'h00);
      // a colon drops a half-read record and a half-read byte
      send_char(ihex_pkg::CHAR_COLON, 1'b0);
      send_hex_byte(8'h01);
      send_char(digit_char(4'hA), 1'b0);
      send_record(1'b0, 1, 16'h0000, ihex_pkg::REC_DATA, 8'h00);
      // after the end record nothing counts until the next file start
      send_record(1'b0, 0, 16'h0000, ihex_pkg::REC_END, ihex_pkg::BYTE_ALL_ONES);
      send_record(1'b0, 1, 16'h0001, ihex_pkg::REC_DATA, 8'h00);
   endtask

   task automatic test_end_and_error_reports();
      send_record(1'b1, 0, 16'h0000, ihex_pkg::REC_END, 8'h7E);
      send_record(1'b1, 0, 16'hFFFF, 8'hFF, 8'h00);
      // file that does not open with a colon, then stopped
      send_char(CHAR_Q, 1'b1);
      send_char(ihex_pkg::CHAR_COLON, 1'b0);
   endtask

   task automatic test_write_limit_extremes();
      set_write_limit('0);
      send_record(1'b1, 1, 16'h0000, ihex_pkg::REC_DATA, 8'h00);
      // addresses past FFFF keep counting but never write
      set_write_limit(ihex_pkg::LIMIT_MAX);
      send_record(1'b1, 3, 16'hFFFE, ihex_pkg::REC_DATA, 8'h00);
      set_write_limit('1);
      send_record(1'b1, 2, 16'hFFFF, ihex_pkg::REC_DATA, 8'h00);
   endtask

   task automatic test_output_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      hold_request = HOLD_CYCLES;
      send_record(1'b1, 48, 16'h0200, ihex_pkg::REC_DATA, 8'h00);
      send_record(1'b0, 0, 16'h0000, ihex_pkg::REC_END, ihex_pkg::BYTE_ALL_ONES);
      wait_quiet();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int n_chars,
                                      input logic [ihex_pkg::LIMIT_W-1:0] limit);
      int stop_at;
      set_write_limit(limit);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      noise_pct = 3;
      stop_at = chars_sent + n_chars;
      while (chars_sent < stop_at) send_random_file();
      wait_quiet();
   endtask

   // result side ready, with random stalls and the occasional long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      parse_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $error("unexpected result: kind %0d address %h data %h",
                   rsp_kind, rsp_address, rsp_data);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            results_checked++;
            if (want.kind == ihex_pkg::KIND_WRITE) writes_checked++;
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               error_count++;
            end
            if (rsp_address !== want.address) begin
               $error("address: expected %h, got %h", want.address, rsp_address);
               error_count++;
            end
            if (rsp_data !== want.data) begin
               $error("data: expected %h, got %h", want.data, rsp_data);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   quiet_cycles, pending_events.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_ignored_before_file_start();
      test_data_records();
      test_end_and_error_reports();
      test_write_limit_extremes();
      test_output_backpressure();
      test_random_traffic(0, 0, 340, 17'($urandom_range(65536, 0)));
      test_random_traffic(67, 0, 340, ihex_pkg::LIMIT_MAX);
      test_random_traffic(0, 67, 340, '1);
      test_random_traffic(15, 15, 340, 17'($urandom_range(131071, 0)));
      wait_quiet();
      $display("covered %0d characters, %0d results checked (%0d memory writes)",
               chars_sent, results_checked, writes_checked);
      $display("traffic: no gaps, sender gaps, receiver stalls, both; limits 0 to 1FFFF");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
